// ----- hdl/c2p_pkg.sv -----
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants for the cartesian to polar unit
// Location codes, CORDIC arctangent table and datapath widths.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int C2P_COORD_BITS      = 16;
  localparam int C2P_ANGLE_FRAC_BITS = 7;

  // CORDIC datapath: coordinates are aligned so that their top lands on bit 59
  localparam int CORDIC_STAGES = 28;
  localparam int CORDIC_ALIGN  = 60;
  localparam int CW            = 62;
  localparam int ZW            = 32;
  localparam int ZFRAC         = 24;

  // atan(2^-i) in units of 2^-24 degree
  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7
  };

  typedef enum logic [2:0] {
    LOC_ORIGIN = 3'd0,
    LOC_Q1     = 3'd1,
    LOC_Q2     = 3'd2,
    LOC_Q3     = 3'd3,
    LOC_Q4     = 3'd4,
    LOC_X_AXIS = 3'd5,
    LOC_Y_AXIS = 3'd6
  } loc_t;

  typedef struct packed {
    loc_t loc;
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

// ----- hdl/c2p_if.sv -----
// ----------------------------------------------------------------------------
// c2p_if: valid/ready channels of the cartesian to polar unit
// Point channel (coordinates in) and polar channel (results out).
// ----------------------------------------------------------------------------
interface c2p_in_if import c2p_pkg::*; #(
  parameter int COORD_BITS = C2P_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface c2p_out_if import c2p_pkg::*; #(
  parameter int MAG_BITS = C2P_COORD_BITS,
  parameter int ANG_BITS = 9 + C2P_ANGLE_FRAC_BITS
) ();
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic [ANG_BITS-1:0] angle_deg;
  loc_t                location;

  modport source (output valid, output magnitude, output angle_deg, output location,
                  input ready);
  modport sink   (input valid, input magnitude, input angle_deg, input location,
                  output ready);
endinterface

// ----- hdl/c2p_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// c2p_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates (x, y) towards the x axis by atan(2^-STAGE) and accumulates z.
// ----------------------------------------------------------------------------
module c2p_cordic_cell import c2p_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ANG = ATAN_TAB[STAGE];

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [ZW-1:0] z_nxt, z_r;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    // rotate clockwise while y is still non-negative
    if (!y_i[CW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ----- hdl/c2p_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// c2p_sqrt_cell: one digit of a restoring integer square root
// Settles one root bit, whose square weight is 2^SHIFT, per cell.
// ----------------------------------------------------------------------------
module c2p_sqrt_cell #(
  parameter int SW    = 32,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] op_i,
  input  logic [SW-1:0] res_i,
  output logic [SW-1:0] op_o,
  output logic [SW-1:0] res_o
);

  localparam logic [SW-1:0] BIT = {{(SW-1){1'b0}}, 1'b1} << SHIFT;

  logic [SW:0]   trial;
  logic          take;
  logic [SW-1:0] op_nxt, res_nxt, op_r, res_r;

  always_comb begin
    trial = {1'b0, res_i} + {1'b0, BIT};
    take  = {1'b0, op_i} >= trial;
    if (take) begin
      op_nxt  = op_i - trial[SW-1:0];
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      op_nxt  = op_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r  <= op_nxt;
      res_r <= res_nxt;
    end
  end

  assign op_o  = op_r;
  assign res_o = res_r;

endmodule

// ----- hdl/c2p_delay.sv -----
// ----------------------------------------------------------------------------
// c2p_delay: enabled shift line
// Holds a word for DEPTH pipeline advances to balance the two datapaths.
// ----------------------------------------------------------------------------
module c2p_delay #(
  parameter type T     = logic,
  parameter int  DEPTH = 1
) (
  input  logic clk,
  input  logic en,
  input  T     d,
  output T     q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      T line_r [DEPTH];

      always_ff @(posedge clk) begin
        if (en) begin
          line_r[0] <= d;
          for (int k = 1; k < DEPTH; k++) begin
            line_r[k] <= line_r[k-1];
          end
        end
      end

      assign q = line_r[DEPTH-1];
    end
  endgenerate

endmodule

// ----- hdl/cartesian_to_polar_quadrant_unit.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_polar_quadrant_unit: point to magnitude, angle and location
// The longer of the 28-cell CORDIC chain and the sqrt digit chain sets the
//   pipeline length. A two-entry output stage decouples stalls.
// Throughput: one word per cycle while the skid entry is empty.
// Reset: synchronous active-low rst_n clears all valid flags; no data reset.
// ----------------------------------------------------------------------------
module cartesian_to_polar_quadrant_unit import c2p_pkg::*; #(
  parameter int COORD_BITS      = C2P_COORD_BITS,
  parameter int ANGLE_FRAC_BITS = C2P_ANGLE_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  c2p_in_if.sink           in_ch,
  c2p_out_if.source        out_ch
);

  localparam int CB     = COORD_BITS;
  localparam int F      = ANGLE_FRAC_BITS;
  localparam int SW     = 2 * CB;
  localparam int AW     = 9 + F;
  localparam int TW     = 7 + F;
  localparam int XSH    = CORDIC_ALIGN - CB;
  localparam int RSH    = ZFRAC - F;
  localparam int ANG_LEN = CORDIC_STAGES + 1;
  localparam int MAG_LEN = CB + 3;
  localparam int L      = (ANG_LEN > MAG_LEN) ? ANG_LEN : MAG_LEN;
  localparam int PAD_A  = L - ANG_LEN;
  localparam int PAD_M  = L - MAG_LEN;

  localparam logic signed [ZW-1:0] ZMAX = ZW'(90) << ZFRAC;
  localparam logic [ZW-1:0]        ZRND = ZW'(1) << (ZFRAC - 1 - F);
  localparam logic [AW-1:0]        ANG_90  = AW'(90) << F;
  localparam logic [AW-1:0]        ANG_180 = AW'(180) << F;
  localparam logic [AW-1:0]        ANG_270 = AW'(270) << F;
  localparam logic [AW-1:0]        ANG_360 = AW'(360) << F;

  // pipeline advance and output skid stage
  logic          en;
  logic [L:0]    vld_r;
  logic          out_valid_r, skid_v_r;
  logic [CB-1:0] out_mag_r, skid_mag_r;
  logic [AW-1:0] out_ang_r, skid_ang_r;
  loc_t          out_loc_r, skid_loc_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  // ---------------- input stage: absolute values and location --------------
  logic [CB-1:0] xu, yu, ax_nxt, ay_nxt, ax_r, ay_r;
  flags_t        fl_nxt, fl_r;
  logic          zero_x, zero_y;

  always_comb begin
    xu     = in_ch.coord_x;
    yu     = in_ch.coord_y;
    ax_nxt = xu[CB-1] ? (~xu + 1'b1) : xu;
    ay_nxt = yu[CB-1] ? (~yu + 1'b1) : yu;
    zero_x = (xu == '0);
    zero_y = (yu == '0);
    fl_nxt.neg_x = xu[CB-1];
    fl_nxt.neg_y = yu[CB-1];
    priority if (zero_x && zero_y) begin
      fl_nxt.loc = LOC_ORIGIN;
    end else if (zero_y) begin
      fl_nxt.loc = LOC_X_AXIS;
    end else if (zero_x) begin
      fl_nxt.loc = LOC_Y_AXIS;
    end else if (!xu[CB-1] && !yu[CB-1]) begin
      fl_nxt.loc = LOC_Q1;
    end else if (xu[CB-1] && !yu[CB-1]) begin
      fl_nxt.loc = LOC_Q2;
    end else if (xu[CB-1] && yu[CB-1]) begin
      fl_nxt.loc = LOC_Q3;
    end else begin
      fl_nxt.loc = LOC_Q4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      fl_r <= fl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[L-1:0], in_ch.valid};
    end
  end

  // ---------------- angle path: CORDIC chain --------------------------------
  logic signed [CW-1:0] cx [CORDIC_STAGES+1];
  logic signed [CW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];

  assign cx[0] = {{(CW-CB){1'b0}}, ax_r} << XSH;
  assign cy[0] = {{(CW-CB){1'b0}}, ay_r} << XSH;
  assign cz[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
      c2p_cordic_cell #(.STAGE(gi)) u_cell (
        .clk (clk),
        .en  (en),
        .x_i (cx[gi]),
        .y_i (cy[gi]),
        .z_i (cz[gi]),
        .x_o (cx[gi+1]),
        .y_o (cy[gi+1]),
        .z_o (cz[gi+1])
      );
    end
  endgenerate

  logic signed [ZW-1:0] z_d;
  flags_t               fl_d;

  c2p_delay #(.T(logic signed [ZW-1:0]), .DEPTH(PAD_A)) u_z_pad (
    .clk (clk), .en (en), .d (cz[CORDIC_STAGES]), .q (z_d)
  );

  c2p_delay #(.T(flags_t), .DEPTH(CORDIC_STAGES + PAD_A)) u_flag_line (
    .clk (clk), .en (en), .d (fl_r), .q (fl_d)
  );

  // clamp, round to F fraction bits, fold into the quadrant
  logic signed [ZW-1:0] z_cl;
  logic [ZW-1:0]        z_rnd;
  logic [TW-1:0]        t_q;
  logic [AW-1:0]        t_w, ang_nxt, ang_r;
  loc_t                 loc_r;

  always_comb begin
    if (z_d[ZW-1]) begin
      z_cl = '0;
    end else if (z_d > ZMAX) begin
      z_cl = ZMAX;
    end else begin
      z_cl = z_d;
    end
    z_rnd = z_cl + ZRND;
    t_q   = TW'(z_rnd >> RSH);
    t_w   = {{(AW-TW){1'b0}}, t_q};
    unique case (fl_d.loc)
      LOC_ORIGIN: ang_nxt = '0;
      LOC_Q1:     ang_nxt = t_w;
      LOC_Q2:     ang_nxt = ANG_180 - t_w;
      LOC_Q3:     ang_nxt = ANG_180 + t_w;
      LOC_Q4:     ang_nxt = (t_q == '0) ? '0 : ANG_360 - t_w;
      LOC_X_AXIS: ang_nxt = fl_d.neg_x ? ANG_180 : '0;
      LOC_Y_AXIS: ang_nxt = fl_d.neg_y ? ANG_270 : ANG_90;
      default:    ang_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
      loc_r <= fl_d.loc;
    end
  end

  // ---------------- magnitude path: squares and sqrt chain ------------------
  logic [SW-1:0] sqx_r, sqy_r, sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
      sum_r <= sqx_r + sqy_r;
    end
  end

  logic [SW-1:0] sq_op  [CB+1];
  logic [SW-1:0] sq_res [CB+1];

  assign sq_op[0]  = sum_r;
  assign sq_res[0] = '0;

  generate
    for (gi = 0; gi < CB; gi++) begin : g_sqrt
      c2p_sqrt_cell #(.SW(SW), .SHIFT(2 * (CB - 1 - gi))) u_cell (
        .clk   (clk),
        .en    (en),
        .op_i  (sq_op[gi]),
        .res_i (sq_res[gi]),
        .op_o  (sq_op[gi+1]),
        .res_o (sq_res[gi+1])
      );
    end
  endgenerate

  // round to nearest: step up when the remainder exceeds the root
  logic [CB-1:0] mag_nxt, mag_r, mag_d;

  assign mag_nxt = sq_res[CB][CB-1:0]
                 + {{(CB-1){1'b0}}, (sq_op[CB] > sq_res[CB])};

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

  c2p_delay #(.T(logic [CB-1:0]), .DEPTH(PAD_M)) u_mag_pad (
    .clk (clk), .en (en), .d (mag_r), .q (mag_d)
  );

  // ---------------- output register with skid entry -------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= vld_r[L];
      end
    end else if (vld_r[L] && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_valid_r) begin
      if (skid_v_r) begin
        out_mag_r <= skid_mag_r;
        out_ang_r <= skid_ang_r;
        out_loc_r <= skid_loc_r;
      end else begin
        out_mag_r <= mag_d;
        out_ang_r <= ang_r;
        out_loc_r <= loc_r;
      end
    end else if (!skid_v_r) begin
      // park the word leaving the pipeline while the output is held
      skid_mag_r <= mag_d;
      skid_ang_r <= ang_r;
      skid_loc_r <= loc_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.magnitude = out_mag_r;
  assign out_ch.angle_deg = out_ang_r;
  assign out_ch.location  = out_loc_r;

  // ---------------- assertions ----------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry holds a word while the output register is empty");

  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_loc_r == LOC_ORIGIN) |-> (out_mag_r == '0) && (out_ang_r == '0))
    else $error("origin word carries a non-zero magnitude or angle");

  a_q1_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_loc_r == LOC_Q1) |-> (out_ang_r <= ANG_90))
    else $error("first quadrant angle above 90 degrees");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ang_r < ANG_360))
    else $error("angle not below a full turn");

endmodule

// ----- tb/sv/tb_cartesian_to_polar_quadrant_unit.sv -----
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_quadrant_unit: self-checking bench for the polar unit
// Drives points through the valid/ready channel, predicts magnitude, angle and
// location with a bit-true CORDIC and integer square root, and compares every
// result word in order. Covers axes, extremes, quadrant folding and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cartesian_to_polar_quadrant_unit;
  import c2p_pkg::*;

  localparam int        NUM_DIRECTED = 24;
  localparam int        PHASE_ITEMS  = 225;
  localparam int        DRAIN_CYCLES = 40;
  localparam int        LONG_HOLD    = 200;
  localparam logic [15:0] ANG_90     = 16'd11520;
  localparam logic [15:0] ANG_180    = 16'd23040;
  localparam logic [15:0] ANG_270    = 16'd34560;
  localparam longint    FULL_TURN    = 46080;
  localparam longint    QUARTER_Z    = longint'(90) << 24;

  // atan(2^-i) in 2^-24 degree
  localparam longint ARCTAN_STEP [28] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
    115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic [15:0] mag;
    logic [15:0] ang;
    loc_t        loc;
  } polar_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               typed;
    polar_t             want;
  } point_row_t;

  logic clk;
  logic rst_n;

  c2p_in_if  pt_if ();
  c2p_out_if pol_if ();

  cartesian_to_polar_quadrant_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pt_if),
    .out_ch (pol_if)
  );

  polar_t polar_expected_q [$];
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     long_hold_req;
  bit     long_hold_served;
  int     hold_left;
  int     points_sent;
  int     results_checked;
  int     mismatches;
  int     loc_seen [7];

  point_row_t directed_points [NUM_DIRECTED] = '{
    '{16'sd0,      16'sd0,      1'b1, '{16'd0,     16'd0,   LOC_ORIGIN}},
    '{16'sd1,      16'sd0,      1'b1, '{16'd1,     16'd0,   LOC_X_AXIS}},
    '{-16'sd1,     16'sd0,      1'b1, '{16'd1,     ANG_180, LOC_X_AXIS}},
    '{16'sd0,      16'sd1,      1'b1, '{16'd1,     ANG_90,  LOC_Y_AXIS}},
    '{16'sd0,      -16'sd1,     1'b1, '{16'd1,     ANG_270, LOC_Y_AXIS}},
    '{16'sd32767,  16'sd0,      1'b1, '{16'd32767, 16'd0,   LOC_X_AXIS}},
    '{-16'sd32768, 16'sd0,      1'b1, '{16'd32768, ANG_180, LOC_X_AXIS}},
    '{16'sd0,      16'sd32767,  1'b1, '{16'd32767, ANG_90,  LOC_Y_AXIS}},
    '{16'sd0,      -16'sd32768, 1'b1, '{16'd32768, ANG_270, LOC_Y_AXIS}},
    '{-16'sd32768, -16'sd32768, 1'b0, '0},
    '{16'sd32767,  16'sd32767,  1'b0, '0},
    '{-16'sd32768, 16'sd32767,  1'b0, '0},
    '{16'sd32767,  -16'sd32768, 1'b0, '0},
    '{16'sd1,      16'sd1,      1'b0, '0},
    '{-16'sd1,     16'sd1,      1'b0, '0},
    '{-16'sd1,     -16'sd1,     1'b0, '0},
    '{16'sd1,      -16'sd1,     1'b0, '0},
    '{16'sd3,      16'sd4,      1'b0, '0},
    '{-16'sd3,     16'sd4,      1'b0, '0},
    '{16'sd32767,  -16'sd1,     1'b0, '0},
    '{16'sd1,      16'sd32767,  1'b0, '0},
    '{-16'sd32767, -16'sd1,     1'b0, '0},
    '{-16'sd32768, 16'sd1,      1'b0, '0},
    '{16'sd100,    -16'sd7,     1'b0, '0}
  };

  // Magnitude, angle and location of one point, bit-true to the datapath
  function automatic polar_t predict_polar(logic signed [15:0] x, logic signed [15:0] y);
    longint ax, ay, sq, root, cx, cy, dx, dy, z, t;
    int     b, i;
    polar_t r;
    ax   = (x < 0) ? -longint'(x) : longint'(x);
    ay   = (y < 0) ? -longint'(y) : longint'(y);
    sq   = ax * ax + ay * ay;
    root = 0;
    for (b = 16; b >= 0; b--) begin
      if ((root + (longint'(1) << b)) * (root + (longint'(1) << b)) <= sq)
        root += longint'(1) << b;
    end
    if (sq - root * root > root)
      root++;
    r.mag = root[15:0];
    if (ax == 0 && ay == 0) begin
      r.ang = '0;
      r.loc = LOC_ORIGIN;
    end else if (ay == 0) begin
      r.ang = (x < 0) ? ANG_180 : 16'd0;
      r.loc = LOC_X_AXIS;
    end else if (ax == 0) begin
      r.ang = (y < 0) ? ANG_270 : ANG_90;
      r.loc = LOC_Y_AXIS;
    end else begin
      cx = ax <<< 44;
      cy = ay <<< 44;
      z  = 0;
      for (i = 0; i < 28; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          z  += ARCTAN_STEP[i];
        end else begin
          cx -= dx;
          cy += dy;
          z  -= ARCTAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_Z) z = QUARTER_Z;
      t = (z + (longint'(1) << 16)) >> 17;
      if (x >= 0 && y >= 0) begin
        r.ang = t[15:0];
        r.loc = LOC_Q1;
      end else if (x < 0 && y >= 0) begin
        r.ang = 16'(longint'(ANG_180) - t);
        r.loc = LOC_Q2;
      end else if (x < 0) begin
        r.ang = 16'(longint'(ANG_180) + t);
        r.loc = LOC_Q3;
      end else begin
        // fold a zero angle back from a full turn
        r.ang = (t == 0) ? 16'd0 : 16'(FULL_TURN - t);
        r.loc = LOC_Q4;
      end
    end
    return r;
  endfunction

  function automatic logic signed [15:0] random_coord();
    case ($urandom_range(0, 5))
      2:       return 16'($urandom_range(0, 16)) - 16'sd8;
      3: begin
        case ($urandom_range(0, 3))
          0:       return 16'sd32767;
          1:       return -16'sd32768;
          2:       return -16'sd32767;
          default: return 16'sd32766;
        endcase
      end
      4:       return 16'($urandom_range(0, 511)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    pol_if.ready     = 1'b0;
    long_hold_served = 1'b0;
    hold_left        = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_served) begin
        long_hold_served = 1'b1;
        hold_left        = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pol_if.ready <= 1'b0;
      end else begin
        pol_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_polar
    polar_t want;
    if (rst_n && pol_if.valid && pol_if.ready) begin
      results_checked++;
      loc_seen[int'(pol_if.location) % 7]++;
      if (polar_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: mag %0d ang %0d loc %0d", $realtime,
                   pol_if.magnitude, pol_if.angle_deg, pol_if.location);
      end else begin
        want = polar_expected_q.pop_front();
        if (pol_if.magnitude !== want.mag || pol_if.angle_deg !== want.ang ||
            pol_if.location !== want.loc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected mag %0d ang %0d loc %0d, got %0d %0d %0d",
                     $realtime, want.mag, want.ang, want.loc,
                     pol_if.magnitude, pol_if.angle_deg, pol_if.location);
        end
      end
    end
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic typed, polar_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      pt_if.valid <= 1'b0;
    end
    @(negedge clk);
    pt_if.valid   <= 1'b1;
    pt_if.coord_x <= x;
    pt_if.coord_y <= y;
    do @(posedge clk); while (!pt_if.ready);
    polar_expected_q.push_back(typed ? want : predict_polar(x, y));
    points_sent++;
  endtask

  task automatic wait_drained();
    while (polar_expected_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic signed [15:0] px, py;
    int                 ph, n;
    rst_n          = 1'b0;
    pt_if.valid    = 1'b0;
    pt_if.coord_x  = '0;
    pt_if.coord_y  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_points[k])
      send_point(directed_points[k].x, directed_points[k].y,
                 directed_points[k].typed, directed_points[k].want);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      // hold the output off while points keep coming, so the input backs up
      if (ph == 0)
        long_hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        px = random_coord();
        py = random_coord();
        case ($urandom_range(0, 9))
          0:       px = '0;
          1:       py = '0;
          2:       py = px;
          3:       py = -px;
          default: ;
        endcase
        send_point(px, py, 1'b0, '0);
      end
      // pause the sender until every result is home
      @(negedge clk);
      pt_if.valid <= 1'b0;
      wait_drained();
    end

    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d points (%0d directed) over four handshake mixes and a %0d-cycle hold",
             points_sent, NUM_DIRECTED, LONG_HOLD);
    $display("Checked %0d results: origin %0d, Q1-Q4 %0d/%0d/%0d/%0d, x axis %0d, y axis %0d",
             results_checked, loc_seen[0], loc_seen[1], loc_seen[2], loc_seen[3],
             loc_seen[4], loc_seen[5], loc_seen[6]);
    if (mismatches == 0 && polar_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- cartesian_to_polar_quadrant_unit.f -----
hdl/c2p_pkg.sv
hdl/c2p_if.sv
hdl/c2p_cordic_cell.sv
hdl/c2p_sqrt_cell.sv
hdl/c2p_delay.sv
hdl/cartesian_to_polar_quadrant_unit.sv
tb/sv/tb_cartesian_to_polar_quadrant_unit.sv
